/* hdl/sum8_frame_validator_assert.svh */
// Assertion shorthands used by the frame checking module.
// Both sample on clk and stay quiet while rst_n is low.
`ifndef SUM8_FRAME_VALIDATOR_ASSERT_SVH
`define SUM8_FRAME_VALIDATOR_ASSERT_SVH

`define SFV_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfv: same-cycle check failed");

`define SFV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfv: next-cycle check failed");

`endif

/* hdl/sfv_pkg.sv */
`timescale 1ns / 1ps

package sfv_pkg;

  localparam int unsigned MAX_FRAME_DEF = 1024;
  localparam int unsigned MIN_FRAME     = 12;

  localparam int unsigned POS_ADDR_FIRST = 1;
  localparam int unsigned POS_ADDR_LAST  = 6;
  localparam int unsigned POS_CTRL       = 7;
  localparam int unsigned POS_LEN_HI     = 8;
  localparam int unsigned POS_LEN_LO     = 9;

  localparam int unsigned FLEN_W = 11;
  localparam int unsigned ADDR_W = 48;
  localparam int unsigned DLEN_W = 16;
  localparam int unsigned LCMP_W = 17;

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;

  localparam logic [7:0] START_CODE_RST = 8'h68;

  typedef enum logic [0:0] {
    REG_START_CODE = 1'b0
  } sfv_reg_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_SHORT = 3'd1,
    ST_BAD_START = 3'd2,
    ST_BAD_SUM   = 3'd3,
    ST_BAD_LEN   = 3'd4
  } sfv_status_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } sfv_word_t;

  typedef struct packed {
    sfv_status_t        status;
    logic [7:0]         control_code;
    logic [ADDR_W-1:0]  station_address;
    logic [DLEN_W-1:0]  data_length;
    logic [FLEN_W-1:0]  frame_length;
  } sfv_result_t;

endpackage

/* hdl/sfv_cfg_regs.sv */
`timescale 1ns / 1ps

module sfv_cfg_regs import sfv_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output logic [7:0]        start_code
);

  logic [7:0] start_code_r;
  logic       hit_start;
  logic       wr_en;

  assign hit_start = (paddr[CFG_AW-1:2] == REG_START_CODE);
  assign wr_en     = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_code_r <= START_CODE_RST;
    end else if (wr_en && hit_start) begin
      start_code_r <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit_start) begin
      prdata = CFG_DW'(start_code_r);
    end
  end

  assign start_code = start_code_r;

endmodule

/* hdl/sfv_in_stage.sv */
`timescale 1ns / 1ps

module sfv_in_stage import sfv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_frame_byte,
  input  logic       in_last_byte,
  output logic       in_stall,
  input  logic       adv,
  output logic       word_valid,
  output sfv_word_t  word
);

  logic      valid_r;
  sfv_word_t word_r;

  assign in_stall = valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      word_r.data <= in_frame_byte;
      word_r.last <= in_last_byte;
    end
  end

  assign word_valid = valid_r;
  assign word       = word_r;

endmodule

/* hdl/sfv_frame_check.sv */
`timescale 1ns / 1ps
`include "sum8_frame_validator_assert.svh"

module sfv_frame_check import sfv_pkg::*; #(
  parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  start_code,
  input  logic        word_valid,
  input  sfv_word_t   word,
  output logic        adv,
  input  logic        out_stall,
  output logic        out_valid,
  output sfv_result_t result
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAME + 2);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME + 1);
  localparam logic [CNT_W-1:0] CNT_SHOWN_MAX = CNT_W'(MAX_FRAME);

  logic [CNT_W-1:0]  cnt_r;
  logic [7:0]        sum_r;
  logic [7:0]        prev_r;
  logic              first_ok_r;
  logic [ADDR_W-1:0] addr_r;
  logic [7:0]        ctrl_r;
  logic [DLEN_W-1:0] len_r;
  logic              out_valid_r;
  sfv_result_t       result_r;

  logic [CNT_W-1:0]  cnt_nxt;
  logic              start_ok;
  logic [ADDR_W-1:0] addr_nxt;
  logic [7:0]        ctrl_nxt;
  logic [DLEN_W-1:0] len_nxt;
  logic [7:0]        computed;
  logic [LCMP_W-1:0] len_sum;
  logic [CNT_W-1:0]  shown;
  sfv_status_t       status;
  sfv_result_t       result_nxt;

  assign adv = word_valid && (!word.last || !out_valid_r || !out_stall);

  always_comb begin
    cnt_nxt  = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + CNT_W'(1);
    start_ok = (cnt_r == '0) ? (word.data == start_code) : first_ok_r;
    addr_nxt = addr_r;
    ctrl_nxt = ctrl_r;
    len_nxt  = len_r;
    if (cnt_r >= CNT_W'(POS_ADDR_FIRST) && cnt_r <= CNT_W'(POS_ADDR_LAST)) begin
      addr_nxt = {addr_r[ADDR_W-9:0], word.data};
    end else if (cnt_r == CNT_W'(POS_CTRL)) begin
      ctrl_nxt = word.data;
    end else if (cnt_r == CNT_W'(POS_LEN_HI)) begin
      len_nxt = {word.data, len_r[7:0]};
    end else if (cnt_r == CNT_W'(POS_LEN_LO)) begin
      len_nxt = {len_r[15:8], word.data};
    end

    computed = sum_r - prev_r;
    len_sum  = LCMP_W'(len_nxt) + LCMP_W'(MIN_FRAME);
    if (cnt_nxt < CNT_W'(MIN_FRAME)) begin
      status = ST_TOO_SHORT;
    end else if (!start_ok) begin
      status = ST_BAD_START;
    end else if (computed != prev_r) begin
      status = ST_BAD_SUM;
    end else if (cnt_nxt == CNT_MAX || len_sum != LCMP_W'(cnt_nxt)) begin
      status = ST_BAD_LEN;
    end else begin
      status = ST_OK;
    end
    shown = (cnt_nxt == CNT_MAX) ? CNT_SHOWN_MAX : cnt_nxt;

    result_nxt.status          = status;
    result_nxt.control_code    = ctrl_nxt;
    result_nxt.station_address = addr_nxt;
    result_nxt.data_length     = len_nxt;
    result_nxt.frame_length    = FLEN_W'(shown);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      sum_r      <= '0;
      prev_r     <= '0;
      first_ok_r <= 1'b0;
      addr_r     <= '0;
      ctrl_r     <= '0;
      len_r      <= '0;
    end else if (adv) begin
      if (word.last) begin
        cnt_r      <= '0;
        sum_r      <= '0;
        prev_r     <= '0;
        first_ok_r <= 1'b0;
        addr_r     <= '0;
        ctrl_r     <= '0;
        len_r      <= '0;
      end else begin
        if (cnt_r >= CNT_W'(POS_CTRL)) begin
          sum_r <= sum_r + word.data;
        end
        cnt_r      <= cnt_nxt;
        prev_r     <= word.data;
        first_ok_r <= start_ok;
        addr_r     <= addr_nxt;
        ctrl_r     <= ctrl_nxt;
        len_r      <= len_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && word.last) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && word.last) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

  `SFV_ASSERT_SAME(a_ok_len, out_valid_r && result_r.status == ST_OK, result_r.frame_length == FLEN_W'(result_r.data_length + DLEN_W'(MIN_FRAME)))
  `SFV_ASSERT_SAME(a_short_len, out_valid_r && result_r.status == ST_TOO_SHORT, result_r.frame_length < FLEN_W'(MIN_FRAME))
  `SFV_ASSERT_NEXT(a_hold_cnt, !adv, $stable(cnt_r) && $stable(sum_r))
  `SFV_ASSERT_NEXT(a_clear_end, adv && word.last, cnt_r == '0 && sum_r == '0 && out_valid_r)

endmodule

/* hdl/sum8_frame_validator.sv */
// sum8_frame_validator: checks framed byte streams with an 8-bit additive checksum.
// Input channel: in_valid / in_stall carry one word per cycle while in_stall is low,
// in_frame_byte plus in_last_byte marking the final byte of a frame.
// Output channel: out_valid / out_stall carry one result per frame (status, control
// code, station address, data length, frame length), issued for the last byte.
// Config: APB-style port, start_code at byte address 0; pready is always high.
// A frame's result is registered when the frame checker takes its last byte.
// Throughput: one word per cycle while in_stall is low, set by the single registered
// pass of the frame checker.
// While out_stall is high a pending result holds; non-last bytes keep flowing, and
// the next last byte waits in the input register, which raises in_stall.
// Reset (rst_n low, synchronous) clears all frame state and drops any pending result;
// start_code returns to 0x68.
`timescale 1ns / 1ps

module sum8_frame_validator import sfv_pkg::*; #(
  parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_frame_byte,
  input  logic              in_last_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_status,
  output logic [7:0]        out_control_code,
  output logic [ADDR_W-1:0] out_station_address,
  output logic [DLEN_W-1:0] out_data_length,
  output logic [FLEN_W-1:0] out_frame_length,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  logic [7:0]  start_code;
  logic        word_valid;
  sfv_word_t   word;
  logic        adv;
  sfv_result_t result;

  sfv_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .start_code (start_code)
  );

  sfv_in_stage u_in (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_frame_byte (in_frame_byte),
    .in_last_byte  (in_last_byte),
    .in_stall      (in_stall),
    .adv           (adv),
    .word_valid    (word_valid),
    .word          (word)
  );

  sfv_frame_check #(
    .MAX_FRAME (MAX_FRAME)
  ) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_code (start_code),
    .word_valid (word_valid),
    .word       (word),
    .adv        (adv),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .result     (result)
  );

  assign out_status          = result.status;
  assign out_control_code    = result.control_code;
  assign out_station_address = result.station_address;
  assign out_data_length     = result.data_length;
  assign out_frame_length    = result.frame_length;

endmodule
